/* rtl/sfr_pkg.sv */
package sfr_pkg;

  localparam int unsigned PatMax  = 8;
  localparam int unsigned RepMax  = 8;
  localparam int unsigned LenW    = 4;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAT_BYTES = 2'd0,
    CFG_PAT_LEN   = 2'd1,
    CFG_REP_BYTES = 2'd2,
    CFG_REP_LEN   = 2'd3
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic pop;
  } sfr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_emit;
    logic last;
  } sfr_sts_t;

endpackage

/* rtl/sfr_if.sv */
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       string_end;

  modport source (output valid, output out_byte, output byte_present, output string_end,
                  input ready);
  modport sink (input valid, input out_byte, input byte_present, input string_end,
                output ready);
endinterface

/* rtl/substring_find_replace_unit.sv */
// An accepted byte that causes results shows its first result in the next cycle.
// Input waits while results are pending: the result buffer shifts out one byte per
// cycle while the receiver is ready, and input is taken again after the last result.
// Reset (rst_ni, asynchronous, active low) empties the window and the result buffer and
// sets the pattern to one zero byte and the replacement to empty.
module substring_find_replace_unit
  import sfr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  sfr_in_if.sink             item_in_i,
  sfr_out_if.source          item_out_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  sfr_cmd_t cmd;
  sfr_sts_t sts;

  // The controller decides when a transaction is taken on either side; the
  // datapath holds the configuration, the match window and the result burst.
  sfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_in_i.valid),
    .in_ready_o  (item_in_i.ready),
    .out_valid_o (item_out_o.valid),
    .out_ready_i (item_out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // On each accepted byte the window is compared against the pattern. A match
  // loads the replacement into the result buffer; a full window without a
  // match releases its oldest byte; the final byte flushes what is left.
  sfr_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .data_byte_i    (item_in_i.data_byte),
    .final_byte_i   (item_in_i.final_byte),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_byte_o     (item_out_o.out_byte),
    .byte_present_o (item_out_o.byte_present),
    .string_end_o   (item_out_o.string_end)
  );

  // A byte that causes results must present one in the next cycle.
  a_burst_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_in_i.valid && item_in_i.ready && sts.need_emit) |=> item_out_o.valid)
    else $error("result burst did not start after a loading transaction");

  // Input is never taken while results are pending.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(item_in_i.ready && item_out_o.valid))
    else $error("input ready while a result is pending");

  // A result taken that is not the last of its burst is followed by more results.
  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_out_o.valid && item_out_o.ready && !item_out_o.string_end && !sts.last)
      |=> item_out_o.valid)
    else $error("result burst ended early");

  // The string end mark only appears on the last result of a burst.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_out_o.valid && item_out_o.string_end) |-> sts.last)
    else $error("string end marked before the last result");

endmodule

/* rtl/sfr_ctrl.sv */
module sfr_ctrl
  import sfr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  sfr_sts_t sts_i,
  output sfr_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign cmd_o.load  = in_valid_i && in_ready_o;
  assign cmd_o.pop   = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.load && sts_i.need_emit) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (cmd_o.pop && sts_i.last) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/sfr_datapath.sv */
module sfr_datapath
  import sfr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic [7:0]          data_byte_i,
  input  logic                final_byte_i,
  input  sfr_cmd_t            cmd_i,
  output sfr_sts_t            sts_o,
  output logic [7:0]          out_byte_o,
  output logic                byte_present_o,
  output logic                string_end_o
);

  logic [8*PatMax-1:0] pat_bytes_q;
  logic [LenW-1:0]     pat_len_q;
  logic [8*RepMax-1:0] rep_bytes_q;
  logic [LenW-1:0]     rep_len_q;

  logic [7:0]          win_q [PatMax];
  logic [7:0]          win_new [PatMax];
  logic [7:0]          win_d [PatMax];
  logic [LenW-1:0]     win_cnt_q, win_cnt_d;

  logic [8*PatMax-1:0] ebuf_q, ebuf_d;
  logic [LenW-1:0]     rem_q, rem_d;
  logic                empty_q, fin_q;

  logic [LenW-1:0]     plen, rlen, cnt_eff, cnt_new, n_emit;
  logic                full, match;

  // Effective lengths: a zero pattern length counts as one, both saturate.
  always_comb begin
    if (pat_len_q == '0) begin
      plen = LenW'(1);
    end else if (pat_len_q > LenW'(PatMax)) begin
      plen = LenW'(PatMax);
    end else begin
      plen = pat_len_q;
    end
    rlen = (rep_len_q > LenW'(RepMax)) ? LenW'(RepMax) : rep_len_q;
  end

  always_comb begin
    cnt_eff = (win_cnt_q >= plen) ? '0 : win_cnt_q;
    cnt_new = cnt_eff + LenW'(1);
    full    = (cnt_new == plen);
    match   = 1'b1;
    for (int i = 0; i < PatMax; i++) begin
      win_new[i] = (LenW'(i) == cnt_eff) ? data_byte_i : win_q[i];
      if ((LenW'(i) < plen) && (win_new[i] != pat_bytes_q[8*i +: 8])) begin
        match = 1'b0;
      end
    end
  end

  // Work out the burst of result bytes the accepted byte causes.
  always_comb begin
    for (int i = 0; i < PatMax; i++) begin
      ebuf_d[8*i +: 8] = win_new[i];
      win_d[i]         = win_new[i];
    end
    n_emit    = '0;
    win_cnt_d = cnt_new;
    if (full && match) begin
      ebuf_d    = rep_bytes_q;
      n_emit    = rlen;
      win_cnt_d = '0;
    end else if (full) begin
      n_emit    = final_byte_i ? plen : LenW'(1);
      win_cnt_d = plen - LenW'(1);
      for (int i = 0; i < PatMax - 1; i++) begin
        win_d[i] = win_new[i+1];
      end
    end else if (final_byte_i) begin
      n_emit = cnt_new;
    end
    if (final_byte_i) begin
      win_cnt_d = '0;
    end
    rem_d = (n_emit == '0 && final_byte_i) ? LenW'(1) : n_emit;
  end

  assign sts_o.need_emit = (n_emit != '0) || final_byte_i;
  assign sts_o.last      = (rem_q == LenW'(1));

  // An end-only transaction carries a zero byte.
  assign out_byte_o     = empty_q ? 8'h00 : ebuf_q[7:0];
  assign byte_present_o = !empty_q;
  assign string_end_o   = fin_q && (rem_q == LenW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_bytes_q <= '0;
      pat_len_q   <= LenW'(1);
      rep_bytes_q <= '0;
      rep_len_q   <= '0;
      win_cnt_q   <= '0;
      rem_q       <= '0;
      empty_q     <= 1'b0;
      fin_q       <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        win_cnt_q <= win_cnt_d;
        rem_q     <= rem_d;
        empty_q   <= (n_emit == '0);
        fin_q     <= final_byte_i;
      end else if (cmd_i.pop) begin
        rem_q <= rem_q - LenW'(1);
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_PAT_BYTES: pat_bytes_q <= cfg_data_i;
          CFG_PAT_LEN: begin
            pat_len_q <= cfg_data_i[LenW-1:0];
            win_cnt_q <= '0;
          end
          CFG_REP_BYTES: rep_bytes_q <= cfg_data_i;
          CFG_REP_LEN:   rep_len_q   <= cfg_data_i[LenW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      win_q  <= win_d;
      ebuf_q <= ebuf_d;
    end else if (cmd_i.pop) begin
      ebuf_q <= {8'h00, ebuf_q[8*PatMax-1:8]};
    end
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import sfr_pkg::*;

  // One item of the rewritten string as it leaves the block.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       string_end;
  } rewrite_item_t;

  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned HoldOffCycles = 150;
  localparam int unsigned ItemsTotal    = 220;
  localparam int unsigned RandomUntil   = 170;
  localparam int unsigned MaxPrinted    = 40;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0] cfg_data_i;

  sfr_in_if  item_in ();
  sfr_out_if item_out ();

  substring_find_replace_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_in_i   (item_in),
    .item_out_o  (item_out),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Shadow copy of the configuration and of the match window, kept in step with
  // the block by the register writes and the predictor below.
  logic [CfgW-1:0] pat_bytes;
  logic [LenW-1:0] pat_len;
  logic [CfgW-1:0] rep_bytes;
  logic [LenW-1:0] rep_len;
  logic [7:0]      win_bytes [PatMax];
  int unsigned     win_cnt;

  // Predicted items of the rewritten string, oldest first.
  rewrite_item_t rewritten_q [$];
  rewrite_item_t head_item;

  // Source text staged for the sender.
  logic [7:0] text_q [$];

  int unsigned mismatch_count;
  int unsigned bytes_sent;
  bit          idle_en;
  int unsigned hold_off_cycles;

  // The clock runs with an 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Every input of the block gets a known value at time zero.
  initial begin
    clk_i                = 1'b0;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_index_i          = CFG_PAT_BYTES;
    cfg_data_i           = '0;
    item_in.valid        = 1'b0;
    item_in.data_byte    = 8'h00;
    item_in.final_byte   = 1'b0;
  end

  // One line per mismatch. Printing stops after a while so that a badly broken
  // block cannot flood the log, but every mismatch is still counted.
  task automatic report_mismatch(input string what);
    if (mismatch_count < MaxPrinted) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  function automatic int unsigned eff_pat_len();
    if (pat_len == '0) return 1;
    if (pat_len > PatMax) return PatMax;
    return int'(pat_len);
  endfunction

  function automatic int unsigned eff_rep_len();
    if (rep_len > RepMax) return RepMax;
    return int'(rep_len);
  endfunction

  // Predictor: one accepted source byte goes into the window. Once the window
  // is as long as the pattern, either the whole pattern matched (the replacement
  // goes out and the window empties) or its oldest byte cannot start a match and
  // leaves unchanged. The final byte flushes whatever is left. A final byte that
  // produces nothing still closes the string with an item that carries no byte.
  function automatic void rewrite_byte(input logic [7:0] b, input logic fin);
    rewrite_item_t step_out [PatMax + RepMax];
    int unsigned   plen;
    int unsigned   n;
    int unsigned   i;
    bit            hit;
    plen = eff_pat_len();
    n = 0;
    if (win_cnt >= plen) win_cnt = 0;
    win_bytes[win_cnt] = b;
    win_cnt++;
    if (win_cnt == plen) begin
      hit = 1'b1;
      for (i = 0; i < plen; i++) begin
        if (win_bytes[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        for (i = 0; i < eff_rep_len(); i++) begin
          step_out[n] = '{rep_bytes[8*i +: 8], 1'b1, 1'b0};
          n++;
        end
        win_cnt = 0;
      end else begin
        step_out[n] = '{win_bytes[0], 1'b1, 1'b0};
        n++;
        for (i = 1; i < win_cnt; i++) win_bytes[i-1] = win_bytes[i];
        win_cnt--;
      end
    end
    if (fin) begin
      for (i = 0; i < win_cnt; i++) begin
        step_out[n] = '{win_bytes[i], 1'b1, 1'b0};
        n++;
      end
      win_cnt = 0;
      if (n == 0) begin
        step_out[n] = '{8'h00, 1'b0, 1'b0};
        n++;
      end
      step_out[n-1].string_end = 1'b1;
    end
    for (i = 0; i < n; i++) rewritten_q.push_back(step_out[i]);
  endfunction

  // Both channels are sampled at the rising edge. A result is checked before
  // the byte accepted at the same edge is predicted; a byte can never cause a
  // result at its own edge, so the order is safe.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (item_out.valid && item_out.ready) begin
        if (rewritten_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result byte %02h present %0b end %0b",
                                    item_out.out_byte, item_out.byte_present,
                                    item_out.string_end));
        end else begin
          head_item = rewritten_q.pop_front();
          if (item_out.out_byte !== head_item.out_byte) begin
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      item_out.out_byte, head_item.out_byte));
          end
          if (item_out.byte_present !== head_item.byte_present) begin
            report_mismatch($sformatf("byte_present %0b, expected %0b",
                                      item_out.byte_present, head_item.byte_present));
          end
          if (item_out.string_end !== head_item.string_end) begin
            report_mismatch($sformatf("string_end %0b, expected %0b",
                                      item_out.string_end, head_item.string_end));
          end
        end
      end
      if (item_in.valid && item_in.ready) begin
        rewrite_byte(item_in.data_byte, item_in.final_byte);
      end
    end
  end

  // Receiver. A requested hold-off keeps ready low for a counted stretch while
  // the sender keeps offering bytes; otherwise ready drops in short random bursts
  // whenever idling is enabled.
  initial begin
    item_out.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles != 0) begin
        item_out.ready = 1'b0;
        repeat (hold_off_cycles) @(negedge clk_i);
        hold_off_cycles = 0;
        item_out.ready = 1'b1;
      end else if (idle_en && ($urandom_range(0, 5) == 0)) begin
        item_out.ready = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
        item_out.ready = 1'b1;
      end else begin
        item_out.ready = 1'b1;
      end
    end
  end

  // Watchdog: the run is declared hung once no transaction has moved on either
  // channel for the limit. The longest correct quiet stretch is the hold-off.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((item_in.valid && item_in.ready) || (item_out.valid && item_out.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("substring_find_replace_unit regression: fail");
    $finish;
  end

  // Sends one source byte and returns at the falling edge after its transaction.
  // All driving happens at falling edges, so the block sees settled inputs.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (idle_en && ($urandom_range(0, 4) == 0)) begin
      item_in.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    item_in.valid      = 1'b1;
    item_in.data_byte  = b;
    item_in.final_byte = fin;
    do @(posedge clk_i); while (!item_in.ready);
    @(negedge clk_i);
    item_in.valid = 1'b0;
    bytes_sent++;
  endtask

  // Sends the staged text; the last byte carries the final mark if asked.
  task automatic send_text(input bit end_string);
    int unsigned k;
    for (k = 0; k < text_q.size(); k++) begin
      send_byte(text_q[k], end_string && (k == text_q.size() - 1));
    end
  endtask

  // Waits until every predicted item has come out, then lets the block settle.
  // The window may still hold bytes of an unfinished string at that point.
  task automatic wait_drained();
    while (rewritten_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Register write; only called while the block is idle. The shadow copy is
  // updated after the write edge, with the same window discard as the block.
  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] val);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_PAT_BYTES: pat_bytes = val;
      CFG_PAT_LEN: begin
        pat_len = val[LenW-1:0];
        win_cnt = 0;
      end
      CFG_REP_BYTES: rep_bytes = val;
      CFG_REP_LEN:   rep_len = val[LenW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [CfgW-1:0] pb, input logic [LenW-1:0] pl,
                            input logic [CfgW-1:0] rb, input logic [LenW-1:0] rl);
    wait_drained();
    write_reg(CFG_PAT_BYTES, pb);
    write_reg(CFG_PAT_LEN, CfgW'(pl));
    write_reg(CFG_REP_BYTES, rb);
    write_reg(CFG_REP_LEN, CfgW'(rl));
  endtask

  // Builds a source text out of tokens: mostly whole patterns and pattern
  // prefixes, so that matches, near misses and overlaps are common, plus bytes
  // taken from the pattern and a few fully random bytes.
  task automatic make_text(input int unsigned tokens);
    int unsigned plen;
    int unsigned cut;
    int unsigned pick;
    int unsigned pos;
    int unsigned k;
    int unsigned j;
    text_q.delete();
    plen = eff_pat_len();
    for (k = 0; k < tokens; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        cut = plen;
      end else if (pick < 55 && plen > 1) begin
        cut = $urandom_range(1, plen - 1);
      end else begin
        cut = 0;
      end
      for (j = 0; j < cut; j++) text_q.push_back(pat_bytes[8*j +: 8]);
      if (cut == 0) begin
        pos = $urandom_range(0, plen - 1);
        if (pick < 80) text_q.push_back(pat_bytes[8*pos +: 8]);
        else text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Random configuration. Pattern bytes are often drawn from two symbols so
  // that the pattern overlaps itself; lengths reach zero and values above the
  // maximum now and then.
  task automatic random_config();
    logic [CfgW-1:0] pb;
    logic [7:0]      sym_a;
    logic [7:0]      sym_b;
    logic [LenW-1:0] pl;
    logic [LenW-1:0] rl;
    int unsigned     k;
    sym_a = 8'($urandom_range(0, 255));
    sym_b = 8'($urandom_range(0, 255));
    pb = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      for (k = 0; k < PatMax; k++) pb[8*k +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
    end
    case ($urandom_range(0, 9))
      0:       pl = '0;
      1:       pl = LenW'($urandom_range(PatMax + 1, 15));
      2:       pl = LenW'(PatMax);
      default: pl = LenW'($urandom_range(1, 4));
    endcase
    rl = ($urandom_range(0, 7) == 0) ? LenW'($urandom_range(RepMax + 1, 15))
                                     : LenW'($urandom_range(0, RepMax));
    set_config(pb, pl, {$urandom, $urandom}, rl);
  endtask

  // Rewrites one register with a random value, which may change the rules in
  // the middle of a string.
  task automatic random_reg_write();
    cfg_idx_e idx;
    idx = cfg_idx_e'($urandom_range(0, 3));
    if (idx == CFG_PAT_LEN || idx == CFG_REP_LEN) begin
      write_reg(idx, CfgW'($urandom_range(0, 15)));
    end else begin
      write_reg(idx, {$urandom, $urandom});
    end
  endtask

  // After reset the pattern is a single zero byte and the replacement is
  // empty, so zero bytes vanish. A string that is just a zero byte therefore
  // ends with nothing emitted and closes with a byteless end item.
  task automatic test_reset_defaults();
    text_q = {8'h00};
    send_text(1'b1);
    text_q = {8'h41, 8'h00, 8'hFF};
    send_text(1'b1);
  endtask

  // Length limits: a pattern length of zero acts as one, lengths above the
  // maximum saturate. A one-byte string then yields the longest replacement.
  // Eight all-ones bytes against an all-ones pattern with an empty replacement
  // match on the final byte and leave nothing but the end item.
  task automatic test_length_limits();
    int unsigned k;
    set_config(64'h0000_0000_0000_00FF, 4'd0, 64'h0123_4567_89AB_CDEF, 4'd15);
    text_q = {8'hFF};
    send_text(1'b1);
    set_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 64'h0000_0000_0000_0000, 4'd0);
    text_q.delete();
    for (k = 0; k < PatMax; k++) text_q.push_back(8'hFF);
    send_text(1'b1);
  endtask

  // Register writes in the middle of a string. A new replacement applies from
  // the next byte on. A new pattern length throws away what the window holds,
  // so the pending byte never comes out.
  task automatic test_midstring_writes();
    set_config(64'h0000_0000_0000_6261, 4'd2, 64'h0000_0000_0000_0058, 4'd1);
    text_q = {8'h61};
    send_text(1'b0);
    wait_drained();
    write_reg(CFG_REP_BYTES, 64'hFFFF_FFFF_FFFF_FF51);
    text_q = {8'h62};
    send_text(1'b1);
    text_q = {8'h61, 8'h78};
    send_text(1'b0);
    wait_drained();
    write_reg(CFG_PAT_LEN, CfgW'(2));
    text_q = {8'h62};
    send_text(1'b1);
  endtask

  // Scanning does not overlap: "aaa" against "aa" with an empty replacement
  // removes the first two bytes and flushes the third.
  task automatic test_overlap();
    set_config(64'h0000_0000_0000_6161, 4'd2, 64'h0, 4'd0);
    text_q = {8'h61, 8'h61, 8'h61};
    send_text(1'b1);
  endtask

  // Back pressure: the receiver holds off for a long counted stretch while the
  // sender keeps going, so the block fills and stalls its input. Afterwards the
  // sender pauses until every expected transaction has come out.
  task automatic test_backpressure();
    set_config({$urandom, $urandom} & 64'h0101_0101_0101_0101, 4'd2,
               {$urandom, $urandom}, 4'd5);
    hold_off_cycles = HoldOffCycles;
    make_text(16);
    send_text(1'b1);
    wait_drained();
    make_text(8);
    send_text(1'b1);
  endtask

  // Random phases, each with its own configuration. Some strings are split
  // around a register write made while the block is idle.
  task automatic test_random_rewrites();
    int unsigned phase_start;
    while (bytes_sent < RandomUntil) begin
      random_config();
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 30) begin
        make_text($urandom_range(1, 8));
        if ($urandom_range(0, 6) == 0) begin
          send_text(1'b0);
          wait_drained();
          random_reg_write();
          make_text($urandom_range(1, 4));
        end
        send_text(1'b1);
        if ($urandom_range(0, 3) == 0) wait_drained();
      end
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_steady_stream();
    idle_en = 1'b0;
    random_config();
    while (bytes_sent < ItemsTotal) begin
      make_text($urandom_range(1, 8));
      send_text(1'b1);
    end
  endtask

  initial begin
    mismatch_count  = 0;
    bytes_sent      = 0;
    idle_en         = 1'b1;
    hold_off_cycles = 0;
    pat_bytes       = '0;
    pat_len         = LenW'(1);
    rep_bytes       = '0;
    rep_len         = '0;
    win_cnt         = 0;
    foreach (win_bytes[k]) win_bytes[k] = 8'h00;

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_length_limits();
    test_midstring_writes();
    test_overlap();
    test_backpressure();
    test_random_rewrites();
    test_steady_stream();

    // Let the last results drain, then watch a little longer for strays.
    wait_drained();
    repeat (20) @(negedge clk_i);

    if (mismatch_count == 0) begin
      $display("substring_find_replace_unit regression: pass");
    end else begin
      $display("substring_find_replace_unit regression: fail");
    end
    $finish;
  end

endmodule
